### design/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

  // default number of cells and reset value of the capacity register
  localparam int unsigned SPQ_DEPTH = 16;
  localparam logic [4:0] CAP_RESET = 5'd16;

  // field widths
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned FILL_W = 5;

  // operation codes
  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } spq_mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  // one held entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } spq_entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t item;
  } spq_ctrl_t;

endpackage

### design/spq_cell.sv
// one cell of the sorted queue: holds an entry and shifts with its neighbours
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  logic               left_stay_i,
  input  spq_pkg::spq_entry_t left_entry_i,
  input  spq_pkg::spq_entry_t right_entry_i,
  output logic               stay_o,
  output spq_pkg::spq_entry_t entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // entry stays in place on insert when it ranks at or above the new item
  assign stay_o  = occ_i && (entry_q.prio >= ctrl_i.item.prio);
  assign entry_o = entry_q;

  // shift down on insert, shift up on remove
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !stay_o) begin
      entry_d = left_stay_i ? ctrl_i.item : left_entry_i;
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### design/sorted_priority_queue.sv
// sorted priority queue: a row of shifting cells, highest priority at the head
//
// Input channel (in_valid_i / in_ready_o) carries one item: mode_i selects an
// insert of entry_prio_i / entry_data_i or a removal of the head entry. An
// insert lands behind every held entry of equal or higher priority, so equal
// priorities leave in arrival order.
// Output channel (out_valid_o / out_ready_i) returns one result per item:
// status_o, the removed entry on out_prio_o / out_data_o (zero otherwise) and
// fill_count_o, the number held after the operation.
// Every cell compares and shifts in the same cycle; an item's result is
// registered and shows in the cycle after acceptance.
// Throughput is one item per cycle while the receiver keeps up. When the
// receiver stalls, the result register holds and a new item is taken in the
// cycle the held result is taken.
// cfg_we_i / cfg_wdata_i set the capacity in use (0 acts as 1, values above
// the depth act as the depth); lowering it keeps held entries.
// Reset empties the queue and sets the capacity to 16; no clearing pass.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [spq_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [spq_pkg::PRIO_W-1:0] entry_prio_i,
  input  logic [spq_pkg::DATA_W-1:0] entry_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [spq_pkg::PRIO_W-1:0] out_prio_o,
  output logic [spq_pkg::DATA_W-1:0] out_data_o,
  output logic [spq_pkg::FILL_W-1:0] fill_count_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CMP_W-1:0]  cap_eff;
  logic              acc, full, empty;
  spq_ctrl_t         ctrl;
  spq_entry_t        cell_entry [DEPTH];
  logic [DEPTH-1:0]  cell_stay;
  logic [DEPTH-1:0]  cell_occ;

  logic              out_valid_q;
  spq_status_e       status_q, status_d;
  spq_entry_t        res_q, res_d;
  logic [FILL_W-1:0] fill_q;

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // capacity saturated to 1..DEPTH
  always_comb begin
    cap_eff = CMP_W'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end
  end

  assign full  = CMP_W'(count_q) >= cap_eff;
  assign empty = (count_q == '0);

  // operation broadcast to the cells
  always_comb begin
    ctrl.ins       = acc && (mode_i == MODE_INSERT) && !full;
    ctrl.rem       = acc && (mode_i == MODE_REMOVE) && !empty;
    ctrl.item.prio = entry_prio_i;
    ctrl.item.data = entry_data_i;
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_occ[i] = (CNT_W'(i) < count_q);
    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (cell_occ[i]),
      .left_stay_i   ((i == 0) ? 1'b1 : cell_stay[(i == 0) ? 0 : i - 1]),
      .left_entry_i  (cell_entry[(i == 0) ? 0 : i - 1]),
      .right_entry_i (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
      .stay_o        (cell_stay[i]),
      .entry_o       (cell_entry[i])
    );
  end

  // count and result
  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    res_d    = '0;
    if (mode_i == MODE_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d = count_q - CNT_W'(1);
        res_d   = cell_entry[0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
      res_q    <= res_d;
      fill_q   <= FILL_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_prio_o   = res_q.prio;
  assign out_data_o   = res_q.data;
  assign fill_count_o = fill_q;

  // count never passes the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(DEPTH))
    else $error("entry count beyond depth");

  // an accepted item always leaves a result behind
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o)
    else $error("accepted item gave no result");

  // a refused insert leaves the count alone
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (mode_i == MODE_INSERT) && full) |=> $stable(count_q))
    else $error("refused insert changed the count");

  // result count matches the held count
  a_fill_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (fill_count_o == FILL_W'(count_q)))
    else $error("reported fill differs from count");

endmodule
